### sv/ivfc_pkg.sv
package ivfc_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INF_NAN  = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_RESERVED = 2'd3
  } ivfc_status_t;

  typedef enum logic {
    OP_IEEE_TO_VAX = 1'b0,
    OP_VAX_TO_IEEE = 1'b1
  } ivfc_op_t;

  typedef enum logic {
    LAYOUT_STORED  = 1'b0,
    LAYOUT_LOGICAL = 1'b1
  } ivfc_layout_t;

  localparam int unsigned MANT_BITS = 23;
  localparam int unsigned EXP_BITS  = 8;
  localparam int unsigned LZ_BITS   = 5;
  localparam int unsigned EADJ_BITS = 10;

  localparam logic [EXP_BITS-1:0] EXP_ALL_ONES = 8'hFF;
  localparam logic [EXP_BITS-1:0] EXP_ADJ      = 8'd2;

  typedef struct packed {
    logic        op;
    logic [31:0] source_word;
  } ivfc_in_t;

  typedef struct packed {
    logic [31:0]  result_word;
    ivfc_status_t status;
  } ivfc_out_t;

  // decoded source word
  typedef struct packed {
    ivfc_op_t                 op;
    logic                     sign;
    logic [EXP_BITS-1:0]      exp;
    logic [MANT_BITS-1:0]     mant;
    logic                     mag_zero;
    logic                     special;
    logic [LZ_BITS-1:0]       lz;
  } ivfc_dec_t;

  // normalised ieee path and finished vax path
  typedef struct packed {
    ivfc_op_t                 op;
    logic                     sign;
    logic                     mag_zero;
    logic                     special;
    logic signed [EADJ_BITS-1:0] e_adj;
    logic [MANT_BITS-1:0]     mant;
    logic [31:0]              ieee_word;
    ivfc_status_t             ieee_status;
  } ivfc_norm_t;

  function automatic logic [31:0] swap_halves(input logic [31:0] w);
    swap_halves = {w[15:0], w[31:16]};
  endfunction

endpackage

### sv/ivfc_decode.sv
module ivfc_decode import ivfc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  ivfc_layout_t layout,
  input  logic         up_valid,
  input  ivfc_in_t     up_data,
  output logic         up_ready,
  output logic         dn_valid,
  output ivfc_dec_t    dn_data,
  input  logic         dn_ready
);

  logic      valid_r;
  ivfc_dec_t data_r;
  ivfc_dec_t data_nxt;
  logic [31:0] word;
  logic [LZ_BITS-1:0] top_pos;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  // in stored layout, vax-side input is swapped back to the logical value
  always_comb begin
    if (ivfc_op_t'(up_data.op) == OP_VAX_TO_IEEE && layout == LAYOUT_STORED) begin
      word = swap_halves(up_data.source_word);
    end else begin
      word = up_data.source_word;
    end
  end

  // position of the leading one of the mantissa
  always_comb begin
    top_pos = '0;
    for (int i = 0; i < MANT_BITS; i++) begin
      if (word[i]) begin
        top_pos = LZ_BITS'(i);
      end
    end
  end

  always_comb begin
    data_nxt.op       = ivfc_op_t'(up_data.op);
    data_nxt.sign     = word[31];
    data_nxt.exp      = word[30:MANT_BITS];
    data_nxt.mant     = word[MANT_BITS-1:0];
    data_nxt.mag_zero = (word[30:0] == '0);
    data_nxt.special  = (word[30:MANT_BITS] == EXP_ALL_ONES);
    data_nxt.lz       = LZ_BITS'(MANT_BITS - 1) - top_pos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

### sv/ivfc_normalize.sv
module ivfc_normalize import ivfc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  input  ivfc_dec_t  up_data,
  output logic       up_ready,
  output logic       dn_valid,
  output ivfc_norm_t dn_data,
  input  logic       dn_ready
);

  logic       valid_r;
  ivfc_norm_t data_r;
  ivfc_norm_t data_nxt;
  logic [LZ_BITS-1:0]   shamt;
  logic [MANT_BITS-1:0] mant_sh;
  logic [MANT_BITS:0]   mant_hid;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  assign shamt    = up_data.lz + LZ_BITS'(1);
  assign mant_sh  = up_data.mant << shamt;
  assign mant_hid = {1'b1, up_data.mant};

  always_comb begin
    data_nxt.op       = up_data.op;
    data_nxt.sign     = up_data.sign;
    data_nxt.mag_zero = up_data.mag_zero;
    data_nxt.special  = up_data.special;

    // ieee to vax: normalise denormals, bias the exponent
    if (up_data.exp == '0) begin
      data_nxt.mant  = mant_sh;
      data_nxt.e_adj = $signed(EADJ_BITS'(EXP_ADJ))
                       - $signed(EADJ_BITS'(up_data.lz));
    end else begin
      data_nxt.mant  = up_data.mant;
      data_nxt.e_adj = $signed(EADJ_BITS'(up_data.exp))
                       + $signed(EADJ_BITS'(EXP_ADJ));
    end

    // vax to ieee
    data_nxt.ieee_status = ST_OK;
    if (up_data.exp == '0) begin
      data_nxt.ieee_word = '0;
      if (up_data.sign) begin
        data_nxt.ieee_status = ST_RESERVED;
      end
    end else if (up_data.exp > EXP_ADJ) begin
      data_nxt.ieee_word = {up_data.sign, up_data.exp - EXP_ADJ, up_data.mant};
    end else if (up_data.exp == EXP_ADJ) begin
      data_nxt.ieee_word = {up_data.sign, 8'd0, mant_hid[MANT_BITS:1]};
    end else begin
      data_nxt.ieee_word = {up_data.sign, 9'd0, mant_hid[MANT_BITS:2]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

### sv/ivfc_pack.sv
module ivfc_pack import ivfc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  ivfc_layout_t layout,
  input  logic         up_valid,
  input  ivfc_norm_t   up_data,
  output logic         up_ready,
  output logic         dn_valid,
  output ivfc_out_t    dn_data,
  input  logic         dn_stall
);

  logic        valid_r;
  ivfc_out_t   data_r;
  ivfc_out_t   data_nxt;
  logic [31:0] vax_word;
  ivfc_status_t vax_status;

  assign up_ready = !valid_r || !dn_stall;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    vax_status = ST_OK;
    priority if (up_data.mag_zero) begin
      vax_word = '0;
    end else if (up_data.special) begin
      vax_word   = {up_data.sign, EXP_ALL_ONES, {MANT_BITS{1'b0}}};
      vax_status = ST_INF_NAN;
    end else if (up_data.e_adj <= $signed(EADJ_BITS'(0))) begin
      vax_word = '0;
    end else if (up_data.e_adj > $signed(EADJ_BITS'(255))) begin
      vax_word   = {up_data.sign, 31'h7FFF_FFFF};
      vax_status = ST_OVERFLOW;
    end else begin
      vax_word = {up_data.sign, up_data.e_adj[EXP_BITS-1:0], up_data.mant};
    end
  end

  always_comb begin
    if (up_data.op == OP_IEEE_TO_VAX) begin
      data_nxt.status = vax_status;
      if (layout == LAYOUT_STORED) begin
        data_nxt.result_word = swap_halves(vax_word);
      end else begin
        data_nxt.result_word = vax_word;
      end
    end else begin
      data_nxt.status      = up_data.ieee_status;
      data_nxt.result_word = up_data.ieee_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

### sv/ieee_vax_single_float_converter.sv
// ieee single / vax f_floating converter, three register stages
// throughput: one item per cycle while out_stall is low, no stall lost or repeated
// reset (rst_n, synchronous, active low) empties the pipeline and
// sets the layout register to stored order (halves swapped)
module ieee_vax_single_float_converter import ivfc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ivfc_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output ivfc_out_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  ivfc_layout_t layout_r;
  logic         dec_valid;
  logic         dec_ready;
  ivfc_dec_t    dec_data;
  logic         norm_valid;
  logic         norm_ready;
  ivfc_norm_t   norm_data;
  logic         in_ready;

  assign cfg_ready = 1'b1;
  assign in_stall  = !in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layout_r <= LAYOUT_STORED;
    end else if (cfg_valid && cfg_ready) begin
      layout_r <= ivfc_layout_t'(cfg_data);
    end
  end

  ivfc_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .layout   (layout_r),
    .up_valid (in_valid),
    .up_data  (in_data),
    .up_ready (in_ready),
    .dn_valid (dec_valid),
    .dn_data  (dec_data),
    .dn_ready (dec_ready)
  );

  ivfc_normalize u_normalize (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (dec_valid),
    .up_data  (dec_data),
    .up_ready (dec_ready),
    .dn_valid (norm_valid),
    .dn_data  (norm_data),
    .dn_ready (norm_ready)
  );

  ivfc_pack u_pack (
    .clk      (clk),
    .rst_n    (rst_n),
    .layout   (layout_r),
    .up_valid (norm_valid),
    .up_data  (norm_data),
    .up_ready (norm_ready),
    .dn_valid (out_valid),
    .dn_data  (out_data),
    .dn_stall (out_stall)
  );

endmodule

### dv/tb_ieee_vax_single_float_converter.sv
`timescale 1ns / 1ps

module tb_ieee_vax_single_float_converter;
  import ivfc_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 300;
  localparam int N_DIRECTED  = 25;

  typedef struct packed {
    ivfc_layout_t layout;
    ivfc_op_t     op;
    logic [31:0]  word;
    logic         typed;
    logic [31:0]  want_word;
    ivfc_status_t want_status;
  } directed_row_t;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  ivfc_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  ivfc_out_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = 1'b0;

  ivfc_out_t    pending_conversions[$];
  ivfc_layout_t layout_now = LAYOUT_STORED;
  int           send_idle_pct = 0;
  int           stall_pct = 0;
  int           err_count = 0;
  int           cycle_count = 0;
  bit           hold_go = 1'b0;
  logic         hold_on = 1'b0;

  directed_row_t directed_rows [0:N_DIRECTED-1] = '{
    // straight after reset, stored order
    '{LAYOUT_STORED,  OP_IEEE_TO_VAX, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK},
    '{LAYOUT_STORED,  OP_IEEE_TO_VAX, 32'h7F80_0000, 1'b1, 32'h0000_7F80, ST_INF_NAN},
    '{LAYOUT_STORED,  OP_VAX_TO_IEEE, 32'h0000_8000, 1'b1, 32'h0000_0000, ST_RESERVED},
    '{LAYOUT_STORED,  OP_IEEE_TO_VAX, 32'h3F80_0000, 1'b0, 32'h0, ST_OK},
    '{LAYOUT_STORED,  OP_VAX_TO_IEEE, 32'h0000_4080, 1'b0, 32'h0, ST_OK},
    '{LAYOUT_LOGICAL, OP_IEEE_TO_VAX, 32'h8000_0000, 1'b1, 32'h0000_0000, ST_OK},
    '{LAYOUT_LOGICAL, OP_IEEE_TO_VAX, 32'hFF80_0000, 1'b1, 32'hFF80_0000, ST_INF_NAN},
    '{LAYOUT_LOGICAL, OP_IEEE_TO_VAX, 32'h7FC0_0001, 1'b1, 32'h7F80_0000, ST_INF_NAN},
    '{LAYOUT_LOGICAL, OP_IEEE_TO_VAX, 32'hFFFF_FFFF, 1'b1, 32'hFF80_0000, ST_INF_NAN},
    '{LAYOUT_LOGICAL, OP_IEEE_TO_VAX, 32'h7F7F_FFFF, 1'b1, 32'h7FFF_FFFF, ST_OVERFLOW},
    '{LAYOUT_LOGICAL, OP_IEEE_TO_VAX, 32'hFF00_0000, 1'b1, 32'hFFFF_FFFF, ST_OVERFLOW},
    '{LAYOUT_LOGICAL, OP_IEEE_TO_VAX, 32'h0000_0001, 1'b1, 32'h0000_0000, ST_OK},
    '{LAYOUT_LOGICAL, OP_IEEE_TO_VAX, 32'h0040_0000, 1'b0, 32'h0, ST_OK},
    '{LAYOUT_LOGICAL, OP_IEEE_TO_VAX, 32'h0020_0000, 1'b0, 32'h0, ST_OK},
    '{LAYOUT_LOGICAL, OP_IEEE_TO_VAX, 32'h0010_0000, 1'b0, 32'h0, ST_OK},
    '{LAYOUT_LOGICAL, OP_IEEE_TO_VAX, 32'h807F_FFFF, 1'b0, 32'h0, ST_OK},
    '{LAYOUT_LOGICAL, OP_IEEE_TO_VAX, 32'h0080_0000, 1'b0, 32'h0, ST_OK},
    '{LAYOUT_LOGICAL, OP_VAX_TO_IEEE, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK},
    '{LAYOUT_LOGICAL, OP_VAX_TO_IEEE, 32'h8000_0000, 1'b1, 32'h0000_0000, ST_RESERVED},
    '{LAYOUT_LOGICAL, OP_VAX_TO_IEEE, 32'h807F_FFFF, 1'b1, 32'h0000_0000, ST_RESERVED},
    '{LAYOUT_LOGICAL, OP_VAX_TO_IEEE, 32'h007F_FFFF, 1'b1, 32'h0000_0000, ST_OK},
    '{LAYOUT_LOGICAL, OP_VAX_TO_IEEE, 32'h0080_0000, 1'b0, 32'h0, ST_OK},
    '{LAYOUT_LOGICAL, OP_VAX_TO_IEEE, 32'h8100_0001, 1'b0, 32'h0, ST_OK},
    '{LAYOUT_LOGICAL, OP_VAX_TO_IEEE, 32'hFFFF_FFFF, 1'b0, 32'h0, ST_OK},
    '{LAYOUT_LOGICAL, OP_VAX_TO_IEEE, 32'h7FFF_FFFF, 1'b0, 32'h0, ST_OK}
  };

  ieee_vax_single_float_converter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic ivfc_out_t convert_word(input ivfc_layout_t layout, input ivfc_in_t item);
    ivfc_out_t    res;
    logic [31:0]  w;
    logic [31:0]  r;
    logic [23:0]  m24;
    logic         sgn;
    int           e;
    ivfc_status_t st;
    w = item.source_word;
    st = ST_OK;
    r = '0;
    if (item.op == OP_VAX_TO_IEEE && layout == LAYOUT_STORED) w = {w[15:0], w[31:16]};
    sgn = w[31];
    e = int'(w[30:23]);
    if (item.op == OP_IEEE_TO_VAX) begin
      m24 = {1'b0, w[22:0]};
      if (w[30:0] == '0) begin
        r = '0;
      end else if (w[30:23] == EXP_ALL_ONES) begin
        r = {sgn, 8'hFF, 23'd0};
        st = ST_INF_NAN;
      end else begin
        // denormal: normalise by leading-zero shift
        if (e == 0) begin
          m24 = m24 << 1;
          while (!m24[23]) begin
            m24 = m24 << 1;
            e = e - 1;
          end
        end
        e = e + 2;
        if (e <= 0) begin
          r = '0;
        end else if (e > 255) begin
          r = {sgn, 31'h7FFF_FFFF};
          st = ST_OVERFLOW;
        end else begin
          r = {sgn, e[7:0], m24[22:0]};
        end
      end
      if (layout == LAYOUT_STORED) r = {r[15:0], r[31:16]};
    end else begin
      if (e == 0) begin
        r = '0;
        st = sgn ? ST_RESERVED : ST_OK;
      end else if (e > 2) begin
        r = w - 32'h0100_0000;
      end else begin
        // subnormal, truncating shift
        r = {sgn, 31'({1'b1, w[22:0]} >> (3 - e))};
      end
    end
    res.result_word = r;
    res.status = st;
    return res;
  endfunction

  function automatic logic [31:0] random_source(input ivfc_op_t op, input ivfc_layout_t layout);
    logic [31:0] w;
    logic [7:0]  ex;
    logic [22:0] mn;
    case ($urandom_range(7))
      0: ex = 8'd0;
      1: ex = 8'd1;
      2: ex = 8'd2;
      3: ex = 8'd3;
      4: ex = 8'($urandom_range(255, 253));
      default: ex = 8'($urandom);
    endcase
    case ($urandom_range(3))
      0: mn = '0;
      1: mn = 23'd1 << $urandom_range(22);
      2: mn = '1;
      default: mn = 23'($urandom);
    endcase
    w = {1'($urandom_range(1)), ex, mn};
    if ($urandom_range(7) == 0) w = $urandom;
    if (op == OP_VAX_TO_IEEE && layout == LAYOUT_STORED) w = {w[15:0], w[31:16]};
    return w;
  endfunction

  task automatic offer_word(input ivfc_in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_layout(input ivfc_layout_t v);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_conversions.size() != 0);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    layout_now = v;
  endtask

  task automatic run_random_phase(input int idle, input int stall, input ivfc_layout_t layout,
                                  input int count, input bit hold);
    ivfc_in_t item;
    write_layout(layout);
    send_idle_pct = idle;
    stall_pct = stall;
    if (hold) hold_go = 1'b1;
    repeat (count) begin
      item.op = 1'($urandom_range(1));
      item.source_word = random_source(ivfc_op_t'(item.op), layout_now);
      offer_word(item);
      pending_conversions.push_back(convert_word(layout_now, item));
    end
  endtask

  // long receiver hold-off while the sender keeps offering
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= hold_on || ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin : check_transfer
    ivfc_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_conversions.size() == 0) begin
        $error("unexpected result: result_word %h status %0d", out_data.result_word,
               out_data.status);
        err_count++;
      end else begin
        want = pending_conversions.pop_front();
        if (out_data.result_word !== want.result_word) begin
          $error("result_word: expected %h, actual %h", want.result_word, out_data.result_word);
          err_count++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_data.status);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    ivfc_in_t  item;
    ivfc_out_t typed;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      if (directed_rows[i].layout != layout_now) write_layout(directed_rows[i].layout);
      item.op = directed_rows[i].op;
      item.source_word = directed_rows[i].word;
      typed.result_word = directed_rows[i].want_word;
      typed.status = directed_rows[i].want_status;
      offer_word(item);
      pending_conversions.push_back(directed_rows[i].typed ? typed
                                                           : convert_word(layout_now, item));
    end

    run_random_phase(0, 0, LAYOUT_LOGICAL, 120, 1'b0);
    run_random_phase(49, 0, LAYOUT_STORED, 120, 1'b0);
    run_random_phase(0, 49, LAYOUT_LOGICAL, 120, 1'b0);
    run_random_phase(30, 30, LAYOUT_STORED, 120, 1'b0);
    run_random_phase(0, 0, LAYOUT_LOGICAL, 60, 1'b1);
    run_random_phase(30, 30, LAYOUT_LOGICAL, 110, 1'b0);

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_conversions.size() != 0);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
